FILE: sv/amfm_pkg.sv
`timescale 1ns / 1ps

package amfm_pkg;

	typedef longint unsigned u64_t;

	localparam int TABLE_INDEX_BITS = 10;
	localparam int SINE_BITS        = 16;
	localparam int AMPLITUDE_BITS   = 12;

	localparam int FULL_SCALE   = (1 << SINE_BITS) - 1;
	localparam int ROM_DEPTH    = (1 << TABLE_INDEX_BITS) + 1;
	localparam int ROM_IDX_W    = TABLE_INDEX_BITS + 1;
	localparam int TAYLOR_TERMS = 12;
	localparam u64_t HALF_PI_Q30 = 64'd1686629713;

	// 2n * (2n + 1) for terms 1 .. TAYLOR_TERMS
	localparam u64_t TAYLOR_DEN [TAYLOR_TERMS] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
		64'd156, 64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600};

	localparam int PHASE_W   = 32;
	localparam int IDX_W     = 32;
	localparam int AMP_W     = 12;
	localparam int STEP_W    = 32;
	localparam int DEV_W     = 32;
	localparam int CAR_W     = 13;
	localparam int MSG_W     = 13;
	localparam int MOD_W     = 14;
	localparam int OFF_SHIFT = 8;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 32;
	localparam int MODE_W    = 2;

	localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAR_AMP  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MSG_AMP  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CAR_STEP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MSG_STEP = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DEV      = 3'd5;

	localparam logic [MODE_W-1:0] MODE_AM = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FM = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PM = 2'd2;

	localparam logic [AMP_W-1:0] AMP_MASK = AMP_W'((1 << AMPLITUDE_BITS) - 1);
	localparam logic [ROM_IDX_W-1:0] ROM_HALF = ROM_IDX_W'(1 << TABLE_INDEX_BITS);

	typedef logic signed [SINE_BITS:0] wave_t;
	typedef logic [SINE_BITS-1:0] sine_t;
	typedef sine_t sine_rom_t [ROM_DEPTH];

	// quarter-wave sine, Q30 Taylor series, rounded half up to full scale
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		u64_t x;
		u64_t x2;
		u64_t term;
		u64_t v;
		longint acc;
		for (int k = 0; k < ROM_DEPTH; k++) begin
			x = (HALF_PI_Q30 * u64_t'(k)) >> TABLE_INDEX_BITS;
			x2 = (x * x) >> 30;
			term = x;
			acc = longint'(x);
			for (int n = 1; n <= TAYLOR_TERMS; n++) begin
				term = ((term * x2) >> 30) / TAYLOR_DEN[n - 1];
				if ((n & 1) == 1) begin
					acc = acc - longint'(term);
				end else begin
					acc = acc + longint'(term);
				end
			end
			if (acc < 0) begin
				acc = 0;
			end
			v = (u64_t'(acc) * u64_t'(FULL_SCALE) + (u64_t'(1) << 29)) >> 30;
			if (v > u64_t'(FULL_SCALE)) begin
				v = u64_t'(FULL_SCALE);
			end
			rom[k] = sine_t'(v);
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

	function automatic sine_t wave_mag(input wave_t w);
		logic [SINE_BITS:0] m;
		m = w[SINE_BITS] ? -w : w;
		return m[SINE_BITS-1:0];
	endfunction

endpackage

FILE: sv/amfm_wave.sv
`timescale 1ns / 1ps

module amfm_wave import amfm_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic [PHASE_W-1:0] phase,
	input  logic               cos_sel,
	output wave_t              wave_q
);

	logic [1:0]                  quad;
	logic [TABLE_INDEX_BITS-1:0] addr;
	logic [ROM_IDX_W-1:0]        idx;
	sine_t                       val;
	wave_t                       pos;

	assign quad = phase[PHASE_W-1 -: 2] + {1'b0, cos_sel};
	assign addr = phase[PHASE_W-3 -: TABLE_INDEX_BITS];
	assign idx  = quad[0] ? ROM_HALF - {1'b0, addr} : {1'b0, addr};
	assign val  = SINE_ROM[idx];
	assign pos  = {1'b0, val};

	always_ff @(posedge clk) begin
		if (en) begin
			wave_q <= quad[1] ? -pos : pos;
		end
	end

endmodule

FILE: sv/am_fm_pm_sample_generator.sv
`timescale 1ns / 1ps

// Channel  Handshake              Payload
// in       in_valid / in_stall    sample_index
// out      out_valid / out_stall  carrier_sample, message_sample, modulated_sample
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data (cfg_ready always high)
//
// One item per clock sustained while out_stall is low. Ten-stage pipeline: phase multiply,
// table lookup, scale multiply, two divide-by-full-scale steps; phase add, lookup, product, two more.
// Reset clears valid bits and configuration registers to zero; the sine table is constant.
// out_stall holds the output register; empty stages keep filling, and in_stall
// rises only when the stages ahead of the input are all full.

module am_fm_pm_sample_generator import amfm_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [IDX_W-1:0] sample_index,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [CAR_W-1:0] carrier_sample,
	output logic signed [MSG_W-1:0] message_sample,
	output logic signed [MOD_W-1:0] modulated_sample,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data
);

	localparam int NSTG    = 10;
	localparam int CQ_W    = AMP_W;
	localparam int OQ_W    = DEV_W + OFF_SHIFT;
	localparam int MA_W    = MOD_W - 1;
	localparam int MQ_W    = MOD_W - 1;
	localparam int CPROD_W = AMP_W + SINE_BITS;
	localparam int OPROD_W = DEV_W + SINE_BITS;
	localparam int MPROD_W = MA_W + SINE_BITS;
	localparam int DIV_W   = OPROD_W + OFF_SHIFT;
	localparam int R_W     = SINE_BITS + 2;
	localparam logic [R_W-1:0] FULL_R     = R_W'(FULL_SCALE);
	localparam logic [R_W-1:0] TWO_FULL_R = R_W'(2 * FULL_SCALE);

	// floor(x / FULL_SCALE), low by at most one
	function automatic logic [DIV_W-1:0] div_est(input logic [DIV_W-1:0] x);
		logic [DIV_W:0] acc;
		logic [DIV_W:0] shifted;
		acc = {1'b0, x};
		for (int k = 1; k * SINE_BITS < DIV_W; k++) begin
			acc = acc + (DIV_W + 1)'(x >> (k * SINE_BITS));
		end
		shifted = acc >> SINE_BITS;
		return shifted[DIV_W-1:0];
	endfunction

	function automatic logic [R_W-1:0] div_rem(input logic [DIV_W-1:0] x,
		input logic [DIV_W-1:0] est);
		logic [DIV_W-1:0] t;
		t = x - (est << SINE_BITS) + est;
		return t[R_W-1:0];
	endfunction

	logic [MODE_W-1:0] mode_q;
	logic [AMP_W-1:0]  ac_q;
	logic [AMP_W-1:0]  am_q;
	logic [STEP_W-1:0] cstep_q;
	logic [STEP_W-1:0] mstep_q;
	logic [DEV_W-1:0]  dev_q;

	logic [NSTG:1] vld;
	logic [NSTG:1] adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;

	logic [IDX_W-1:0]   idx_u;
	logic [PHASE_W-1:0] pc_s1, pm_s1;
	logic [PHASE_W-1:0] pc_s2, pc_s3, pc_s4, pc_s5;
	wave_t              wc_s2, wm_s2, wo_s2;
	wave_t              wc_s3, wc_s4, wc_s5, wc_s6, wc_s7;

	logic [CPROD_W-1:0] car_prod_s3, msg_prod_s3, car_prod_s4, msg_prod_s4;
	logic [OPROD_W-1:0] off_prod_s3, off_prod_s4;
	logic               car_neg_s3, msg_neg_s3, off_neg_s3;
	logic               car_neg_s4, msg_neg_s4, off_neg_s4;

	logic [DIV_W-1:0]   car_est_w, msg_est_w, off_est_w;
	logic [CQ_W-1:0]    car_est_s4, msg_est_s4;
	logic [OQ_W-1:0]    off_est_s4;

	logic [R_W-1:0]     car_r, msg_r, off_r;
	logic [CQ_W-1:0]    car_q, msg_q;
	logic [PHASE_W-1:0] off_q;

	logic signed [CAR_W-1:0] carrier_s5, carrier_s6, carrier_s7, carrier_s8;
	logic signed [CAR_W-1:0] carrier_s9, carrier_s10;
	logic signed [MSG_W-1:0] message_s5, message_s6, message_s7, message_s8;
	logic signed [MSG_W-1:0] message_s9, message_s10;
	logic [PHASE_W-1:0]      off_s5;

	logic [PHASE_W-1:0]      pf_s6;
	logic signed [MOD_W-1:0] am_sum_s6, am_sum_s7;
	wave_t                   wf_s7;

	logic [MOD_W-1:0]   am_abs;
	logic [MA_W-1:0]    sel_mag;
	logic               sel_neg;
	wave_t              sel_w;
	logic [MPROD_W-1:0] mod_prod_s8, mod_prod_s9;
	logic               mod_neg_s8, mod_neg_s9;
	logic [DIV_W-1:0]   mod_est_w;
	logic [MQ_W-1:0]    mod_est_s9;
	logic [R_W-1:0]     mod_r;
	logic [MQ_W-1:0]    mod_q;
	logic signed [MOD_W-1:0] modulated_s10;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_AM;
			ac_q    <= '0;
			am_q    <= '0;
			cstep_q <= '0;
			mstep_q <= '0;
			dev_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODE:     mode_q  <= cfg_data[MODE_W-1:0];
				REG_CAR_AMP:  ac_q    <= cfg_data[AMP_W-1:0] & AMP_MASK;
				REG_MSG_AMP:  am_q    <= cfg_data[AMP_W-1:0] & AMP_MASK;
				REG_CAR_STEP: cstep_q <= cfg_data[STEP_W-1:0];
				REG_MSG_STEP: mstep_q <= cfg_data[STEP_W-1:0];
				REG_DEV:      dev_q   <= cfg_data[DEV_W-1:0];
				default: ;
			endcase
		end
	end

	// flow control: a stage moves when it is empty or the next one moves
	assign vld = {v_s10, v_s9, v_s8, v_s7, v_s6, v_s5, v_s4, v_s3, v_s2, v_s1};

	always_comb begin
		adv[NSTG] = !vld[NSTG] || !out_stall;
		for (int k = NSTG - 1; k >= 1; k--) begin
			adv[k] = !vld[k] || adv[k+1];
		end
	end

	assign in_stall = !adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else begin
			if (adv[1])  v_s1  <= in_valid;
			if (adv[2])  v_s2  <= v_s1;
			if (adv[3])  v_s3  <= v_s2;
			if (adv[4])  v_s4  <= v_s3;
			if (adv[5])  v_s5  <= v_s4;
			if (adv[6])  v_s6  <= v_s5;
			if (adv[7])  v_s7  <= v_s6;
			if (adv[8])  v_s8  <= v_s7;
			if (adv[9])  v_s9  <= v_s8;
			if (adv[10]) v_s10 <= v_s9;
		end
	end

	// s1: phases
	assign idx_u = sample_index;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			pc_s1 <= PHASE_W'(idx_u * cstep_q);
			pm_s1 <= PHASE_W'(idx_u * mstep_q);
		end
	end

	// s2: table lookups
	amfm_wave u_wave_c (
		.clk     (clk),
		.en      (adv[2]),
		.phase   (pc_s1),
		.cos_sel (1'b1),
		.wave_q  (wc_s2)
	);

	amfm_wave u_wave_m (
		.clk     (clk),
		.en      (adv[2]),
		.phase   (pm_s1),
		.cos_sel (1'b1),
		.wave_q  (wm_s2)
	);

	// FM deviates by the message sine, PM by its cosine
	amfm_wave u_wave_o (
		.clk     (clk),
		.en      (adv[2]),
		.phase   (pm_s1),
		.cos_sel (mode_q != MODE_FM),
		.wave_q  (wo_s2)
	);

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			pc_s2 <= pc_s1;
		end
	end

	// s3: scaling products
	always_ff @(posedge clk) begin
		if (adv[3]) begin
			pc_s3       <= pc_s2;
			wc_s3       <= wc_s2;
			car_prod_s3 <= CPROD_W'(ac_q) * CPROD_W'(wave_mag(wc_s2));
			msg_prod_s3 <= CPROD_W'(am_q) * CPROD_W'(wave_mag(wm_s2));
			off_prod_s3 <= OPROD_W'(dev_q) * OPROD_W'(wave_mag(wo_s2));
			car_neg_s3  <= wc_s2[SINE_BITS];
			msg_neg_s3  <= wm_s2[SINE_BITS];
			off_neg_s3  <= wo_s2[SINE_BITS];
		end
	end

	// s4: quotient estimates
	assign car_est_w = div_est(DIV_W'(car_prod_s3));
	assign msg_est_w = div_est(DIV_W'(msg_prod_s3));
	assign off_est_w = div_est({off_prod_s3, OFF_SHIFT'(0)});

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			pc_s4       <= pc_s3;
			wc_s4       <= wc_s3;
			car_prod_s4 <= car_prod_s3;
			msg_prod_s4 <= msg_prod_s3;
			off_prod_s4 <= off_prod_s3;
			car_neg_s4  <= car_neg_s3;
			msg_neg_s4  <= msg_neg_s3;
			off_neg_s4  <= off_neg_s3;
			car_est_s4  <= car_est_w[CQ_W-1:0];
			msg_est_s4  <= msg_est_w[CQ_W-1:0];
			off_est_s4  <= off_est_w[OQ_W-1:0];
		end
	end

	// s5: correction and sign
	assign car_r = div_rem(DIV_W'(car_prod_s4), DIV_W'(car_est_s4));
	assign msg_r = div_rem(DIV_W'(msg_prod_s4), DIV_W'(msg_est_s4));
	assign off_r = div_rem({off_prod_s4, OFF_SHIFT'(0)}, DIV_W'(off_est_s4));
	assign car_q = car_est_s4 + CQ_W'(car_r >= FULL_R);
	assign msg_q = msg_est_s4 + CQ_W'(msg_r >= FULL_R);
	assign off_q = off_est_s4[PHASE_W-1:0] + PHASE_W'(off_r >= FULL_R);

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			pc_s5      <= pc_s4;
			wc_s5      <= wc_s4;
			carrier_s5 <= car_neg_s4 ? -$signed(CAR_W'(car_q)) : $signed(CAR_W'(car_q));
			message_s5 <= msg_neg_s4 ? -$signed(MSG_W'(msg_q)) : $signed(MSG_W'(msg_q));
			off_s5     <= off_neg_s4 ? PHASE_W'(0) - off_q : off_q;
		end
	end

	// s6: modulated phase, AM amplitude
	always_ff @(posedge clk) begin
		if (adv[6]) begin
			pf_s6      <= pc_s5 + off_s5;
			am_sum_s6  <= $signed(MOD_W'(ac_q)) + MOD_W'(message_s5);
			wc_s6      <= wc_s5;
			carrier_s6 <= carrier_s5;
			message_s6 <= message_s5;
		end
	end

	// s7: modulated carrier lookup
	amfm_wave u_wave_f (
		.clk     (clk),
		.en      (adv[7]),
		.phase   (pf_s6),
		.cos_sel (1'b1),
		.wave_q  (wf_s7)
	);

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			am_sum_s7  <= am_sum_s6;
			wc_s7      <= wc_s6;
			carrier_s7 <= carrier_s6;
			message_s7 <= message_s6;
		end
	end

	// s8: mode select and product
	assign am_abs = am_sum_s7[MOD_W-1] ? -am_sum_s7 : am_sum_s7;

	always_comb begin
		case (mode_q)
			MODE_AM: begin
				sel_mag = am_abs[MA_W-1:0];
				sel_neg = am_sum_s7[MOD_W-1];
				sel_w   = wc_s7;
			end
			MODE_FM, MODE_PM: begin
				sel_mag = MA_W'(ac_q);
				sel_neg = 1'b0;
				sel_w   = wf_s7;
			end
			default: begin
				sel_mag = '0;
				sel_neg = 1'b0;
				sel_w   = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			mod_prod_s8 <= MPROD_W'(sel_mag) * MPROD_W'(wave_mag(sel_w));
			mod_neg_s8  <= sel_neg ^ sel_w[SINE_BITS];
			carrier_s8  <= carrier_s7;
			message_s8  <= message_s7;
		end
	end

	// s9: quotient estimate
	assign mod_est_w = div_est(DIV_W'(mod_prod_s8));

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			mod_prod_s9 <= mod_prod_s8;
			mod_est_s9  <= mod_est_w[MQ_W-1:0];
			mod_neg_s9  <= mod_neg_s8;
			carrier_s9  <= carrier_s8;
			message_s9  <= message_s8;
		end
	end

	// s10: correction, output register
	assign mod_r = div_rem(DIV_W'(mod_prod_s9), DIV_W'(mod_est_s9));
	assign mod_q = mod_est_s9 + MQ_W'(mod_r >= FULL_R);

	always_ff @(posedge clk) begin
		if (adv[10]) begin
			modulated_s10 <= mod_neg_s9 ? -$signed(MOD_W'(mod_q)) : $signed(MOD_W'(mod_q));
			carrier_s10   <= carrier_s9;
			message_s10   <= message_s9;
		end
	end

	assign out_valid        = v_s10;
	assign carrier_sample   = carrier_s10;
	assign message_sample   = message_s10;
	assign modulated_sample = modulated_s10;

`ifndef ASSERT_OFF
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1)
		else $error("input stalled with first stage empty");

	a_full_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(&vld) && out_stall |-> in_stall)
		else $error("item accepted into a full stalled pipeline");

	a_car_est: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (car_r < TWO_FULL_R) && (msg_r < TWO_FULL_R))
		else $error("sample quotient estimate off by more than one");

	a_off_est: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> off_r < TWO_FULL_R)
		else $error("phase offset quotient estimate off by more than one");

	a_mod_est: assert property (@(posedge clk) disable iff (!arst_n)
		v_s9 |-> mod_r < TWO_FULL_R)
		else $error("modulated quotient estimate off by more than one");
`endif

endmodule

FILE: sim/am_fm_pm_sample_checker.sv
`timescale 1ns / 1ps

module am_fm_pm_sample_checker import amfm_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_stall,
	input  logic signed [IDX_W-1:0] sample_index,
	input  logic                    out_valid,
	input  logic                    out_stall,
	input  logic signed [CAR_W-1:0] carrier_sample,
	input  logic signed [MSG_W-1:0] message_sample,
	input  logic signed [MOD_W-1:0] modulated_sample,
	input  logic                    cfg_valid,
	input  logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	output int                      mismatches,
	output int                      outstanding
);

	typedef longint unsigned wide_t;

	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic [CAR_W-1:0] carrier;
		logic [MSG_W-1:0] message;
		logic [MOD_W-1:0] modulated;
	} samples_t;

	logic [SINE_BITS-1:0] quarter_sine [ROM_DEPTH];

	logic [MODE_W-1:0]  cur_mode;
	logic [AMP_W-1:0]   cur_car_amp;
	logic [AMP_W-1:0]   cur_msg_amp;
	logic [STEP_W-1:0]  cur_car_step;
	logic [STEP_W-1:0]  cur_msg_step;
	logic [DEV_W-1:0]   cur_dev;

	samples_t expected_samples [$];
	int fail_total = 0;

	assign mismatches = fail_total;

	// quarter-wave table: Q30 Taylor sine, 12 terms, rounded half up to full scale
	initial begin
		wide_t x;
		wide_t xsq;
		wide_t term;
		wide_t v;
		longint acc;
		for (int k = 0; k < ROM_DEPTH; k++) begin
			x = (HALF_PI_Q30 * wide_t'(k)) >> TABLE_INDEX_BITS;
			xsq = (x * x) >> 30;
			term = x;
			acc = longint'(x);
			for (int n = 1; n <= 12; n++) begin
				term = ((term * xsq) >> 30) / wide_t'((2 * n) * (2 * n + 1));
				if (n % 2 == 1) begin
					acc -= longint'(term);
				end else begin
					acc += longint'(term);
				end
			end
			if (acc < 0) begin
				acc = 0;
			end
			v = (wide_t'(acc) * wide_t'(FULL_SCALE) + (wide_t'(1) << 29)) >> 30;
			if (v > wide_t'(FULL_SCALE)) begin
				v = wide_t'(FULL_SCALE);
			end
			quarter_sine[k] = v[SINE_BITS-1:0];
		end
	end

	function automatic int sine_at(input logic [PHASE_W-1:0] p);
		logic [TABLE_INDEX_BITS-1:0] addr;
		int v;
		addr = p[PHASE_W-3 -: TABLE_INDEX_BITS];
		if (p[PHASE_W-2]) begin
			v = quarter_sine[(1 << TABLE_INDEX_BITS) - addr];
		end else begin
			v = quarter_sine[addr];
		end
		return p[PHASE_W-1] ? -v : v;
	endfunction

	function automatic int cosine_at(input logic [PHASE_W-1:0] p);
		return sine_at(p + 32'h4000_0000);
	endfunction

	// amplitude times wave value over full scale, truncated toward zero
	function automatic longint scale_trunc(input longint amp, input int w);
		wide_t mag_a;
		wide_t mag_w;
		wide_t m;
		mag_a = (amp < 0) ? wide_t'(-amp) : wide_t'(amp);
		mag_w = (w < 0) ? wide_t'(-longint'(w)) : wide_t'(w);
		m = (mag_a * mag_w) / wide_t'(FULL_SCALE);
		return ((amp < 0) != (w < 0)) ? -longint'(m) : longint'(m);
	endfunction

	// deviation is in 2^-24 turn, offset in 2^-32 turn
	function automatic logic [PHASE_W-1:0] phase_shift(input logic [DEV_W-1:0] dv, input int w);
		wide_t mag_w;
		wide_t prod;
		wide_t q;
		wide_t r;
		logic [PHASE_W-1:0] mag;
		mag_w = (w < 0) ? wide_t'(-longint'(w)) : wide_t'(w);
		prod = wide_t'(dv) * mag_w;
		q = prod / wide_t'(FULL_SCALE);
		r = prod % wide_t'(FULL_SCALE);
		mag = PHASE_W'((q << OFF_SHIFT) + (r << OFF_SHIFT) / wide_t'(FULL_SCALE));
		return (w < 0) ? (32'd0 - mag) : mag;
	endfunction

	function automatic samples_t predict_samples(input logic [IDX_W-1:0] n);
		samples_t s;
		logic [PHASE_W-1:0] car_phase;
		logic [PHASE_W-1:0] msg_phase;
		longint car;
		longint msg;
		longint modv;
		car_phase = n * cur_car_step;
		msg_phase = n * cur_msg_step;
		car = scale_trunc(longint'(cur_car_amp), cosine_at(car_phase));
		msg = scale_trunc(longint'(cur_msg_amp), cosine_at(msg_phase));
		case (cur_mode)
			MODE_AM: modv = scale_trunc(longint'(cur_car_amp) + msg, cosine_at(car_phase));
			MODE_FM: modv = scale_trunc(longint'(cur_car_amp),
				cosine_at(car_phase + phase_shift(cur_dev, sine_at(msg_phase))));
			MODE_PM: modv = scale_trunc(longint'(cur_car_amp),
				cosine_at(car_phase + phase_shift(cur_dev, cosine_at(msg_phase))));
			default: modv = 0;
		endcase
		s.index = n;
		s.carrier = CAR_W'(car);
		s.message = MSG_W'(msg);
		s.modulated = MOD_W'(modv);
		return s;
	endfunction

	task automatic report(input string what, input logic [IDX_W-1:0] n, input int want,
			input int got);
		fail_total++;
		if (fail_total <= 10) begin
			$display("mismatch %s at index %0d: expected %0d, got %0d", what, $signed(n), want,
				got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		samples_t want;
		if (!arst_n) begin
			cur_mode = MODE_AM;
			cur_car_amp = '0;
			cur_msg_amp = '0;
			cur_car_step = '0;
			cur_msg_step = '0;
			cur_dev = '0;
			expected_samples.delete();
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MODE:     cur_mode = cfg_data[MODE_W-1:0];
					REG_CAR_AMP:  cur_car_amp = cfg_data[AMP_W-1:0] & AMP_MASK;
					REG_MSG_AMP:  cur_msg_amp = cfg_data[AMP_W-1:0] & AMP_MASK;
					REG_CAR_STEP: cur_car_step = cfg_data;
					REG_MSG_STEP: cur_msg_step = cfg_data;
					REG_DEV:      cur_dev = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				expected_samples.push_back(predict_samples(sample_index));
			end
			if (out_valid && !out_stall) begin
				if (expected_samples.size() == 0) begin
					fail_total++;
					if (fail_total <= 10) begin
						$display("unexpected result: carrier %0d message %0d modulated %0d",
							carrier_sample, message_sample, modulated_sample);
					end
				end else begin
					want = expected_samples.pop_front();
					if (want.carrier !== carrier_sample) begin
						report("carrier_sample", want.index, int'($signed(want.carrier)),
							int'(carrier_sample));
					end
					if (want.message !== message_sample) begin
						report("message_sample", want.index, int'($signed(want.message)),
							int'(message_sample));
					end
					if (want.modulated !== modulated_sample) begin
						report("modulated_sample", want.index, int'($signed(want.modulated)),
							int'(modulated_sample));
					end
				end
			end
			outstanding <= expected_samples.size();
		end
	end

endmodule

FILE: sim/tb_am_fm_pm_sample_generator.sv
`timescale 1ns / 1ps

module tb_am_fm_pm_sample_generator;
	import amfm_pkg::*;

	localparam int LIMIT_CYCLES  = 200000;
	localparam int SETTLE_CYCLES = 14;
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 160;

	localparam logic [MODE_W-1:0]    MODE_NONE     = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO  = REG_DEV + 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI  = REG_DEV + 3'd2;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic signed [IDX_W-1:0] sample_index;
	logic                    out_valid;
	logic                    out_stall;
	logic signed [CAR_W-1:0] carrier_sample;
	logic signed [MSG_W-1:0] message_sample;
	logic signed [MOD_W-1:0] modulated_sample;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_W-1:0]        cfg_data;

	int mismatches;
	int outstanding;
	int sent_count = 0;
	int cycle_count = 0;

	am_fm_pm_sample_generator i_dut (.*);

	am_fm_pm_sample_checker i_checker (.*);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	// output side: random stalls, one long hold-off, and a quiet stretch
	initial begin
		int hold_left;
		bit held;
		hold_left = 0;
		held = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!held && sent_count >= 400) begin
				held = 1;
				hold_left = HOLD_CYCLES;
				out_stall <= 1'b1;
			end else if (sent_count >= 1000 && sent_count < 1200) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < 9);
			end
		end
	end

	task automatic send_index(input logic [IDX_W-1:0] n);
		int idle_pct;
		idle_pct = (sent_count >= 600 && sent_count < 800) ? 0 : 9;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample_index <= n;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		sent_count++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
	endtask

	task automatic configure(input logic [CFG_W-1:0] mode, input logic [CFG_W-1:0] car_amp,
			input logic [CFG_W-1:0] msg_amp, input logic [CFG_W-1:0] car_step,
			input logic [CFG_W-1:0] msg_step, input logic [CFG_W-1:0] dev);
		write_reg(REG_MODE, mode);
		write_reg(REG_CAR_AMP, car_amp);
		write_reg(REG_MSG_AMP, msg_amp);
		write_reg(REG_CAR_STEP, car_step);
		write_reg(REG_MSG_STEP, msg_step);
		write_reg(REG_DEV, dev);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [CFG_W-1:0] pick_amp();
		int r;
		r = $urandom_range(7);
		if (r == 0) return '0;
		if (r == 1) return CFG_W'(AMP_MASK);
		return CFG_W'($urandom_range(0, 4095));
	endfunction

	function automatic logic [CFG_W-1:0] pick_step();
		return ($urandom_range(7) == 0) ? CFG_W'($urandom_range(0, 1 << 20)) : $urandom();
	endfunction

	function automatic logic [CFG_W-1:0] pick_dev();
		case ($urandom_range(3))
			0: return $urandom();
			1: return CFG_W'($urandom_range(0, 1 << 24));
			2: return CFG_W'($urandom_range(0, 1 << 20));
			default: return '0;
		endcase
	endfunction

	function automatic logic [MODE_W-1:0] pick_mode();
		int r;
		r = $urandom_range(9);
		if (r < 3) return MODE_AM;
		if (r < 6) return MODE_FM;
		if (r < 9) return MODE_PM;
		return MODE_NONE;
	endfunction

	initial begin
		logic [IDX_W-1:0] corner_am [9];
		logic [IDX_W-1:0] corner_fm [6];
		logic [IDX_W-1:0] corner_pm [4];
		logic [CFG_W-1:0] junk;
		corner_am = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'd64, 32'd128, 32'd192, 32'd256};
		corner_fm = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd2, 32'h8000_0000, 32'h7FFF_FFFF};
		corner_pm = '{32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		sample_index <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_MODE;
		cfg_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full-scale AM, steps on quadrant boundaries
		configure(CFG_W'(MODE_AM), 32'd4095, 32'd4095, 32'h0100_0000, 32'h0040_0000, 32'd0);
		foreach (corner_am[i]) send_index(corner_am[i]);
		drain();

		// FM with carrier step and deviation at the top of their range, message step at half turn
		configure(CFG_W'(MODE_FM), 32'd4095, 32'd4095, 32'hFFFF_FFFF, 32'h8000_0000,
			32'hFFFF_FFFF);
		foreach (corner_fm[i]) send_index(corner_fm[i]);
		drain();

		// PM with zero carrier amplitude and zero carrier step
		configure(CFG_W'(MODE_PM), 32'd0, 32'd4095, 32'd0, 32'd1, 32'h0100_0000);
		foreach (corner_pm[i]) send_index(corner_pm[i]);
		drain();

		// unused mode, plus writes to unmapped register indexes
		write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
		write_reg(REG_SPARE_HI, 32'hFFFF_FFFF);
		configure(CFG_W'(MODE_NONE), 32'd2048, 32'd1, 32'h4000_0000, 32'h2000_0000, 32'd5);
		send_index(32'd1);
		send_index(32'd3);
		send_index(32'd5);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			junk = $urandom();
			configure({junk[CFG_W-1:MODE_W], pick_mode()},
				{junk[CFG_W-1:AMP_W], 12'h000} | pick_amp(),
				pick_amp(), pick_step(), pick_step(), pick_dev());
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(7) < 6) begin
					send_index($urandom());
				end else begin
					send_index($urandom_range(0, 4000) - 32'd2000);
				end
			end
			drain();
		end

		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

FILE: am_fm_pm_sample_generator.f
sv/amfm_pkg.sv
sv/amfm_wave.sv
sv/am_fm_pm_sample_generator.sv
sim/am_fm_pm_sample_checker.sv
sim/tb_am_fm_pm_sample_generator.sv
